// ----- design/rta_pkg.sv -----
// Shared types, constants and mask helper for the raster to twiddled address unit.
package rta_pkg;

    // Largest supported size exponent, the widths that follow from it, and the pixel and index widths.
    localparam int MAX_SIZE_LOG2 = 10;
    localparam int EXP_W         = 4;
    localparam int COUNT_W       = MAX_SIZE_LOG2 + 1;
    localparam int ADDR_W        = 20;
    localparam int CODE_W        = ADDR_W;
    localparam int PIXEL_W       = 32;
    localparam int CFG_IDX_W     = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LOG2  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_LOG2 = CFG_IDX_W'(1);

    // Interleave masks and end-of-line limits for one texture shape.
    typedef struct packed {
        logic [CODE_W-1:0]  x_mask;
        logic [CODE_W-1:0]  y_mask;
        logic [COUNT_W-1:0] col_last;
        logic [COUNT_W-1:0] row_last;
    } t_shape;

    // Build the masks: the shorter axis alternates with the longer one in the
    // low bits, and the longer axis owns the leftover high bits.
    function automatic t_shape build_shape(input logic [EXP_W-1:0] wl_raw,
                                           input logic [EXP_W-1:0] hl_raw);
        logic [EXP_W-1:0] wl;
        logic [EXP_W-1:0] hl;
        logic [EXP_W-1:0] m;
        logic [EXP_W:0]   shared;
        logic [EXP_W+1:0] x_top;
        logic [EXP_W+1:0] y_top;
        t_shape           res;
        wl = (wl_raw > EXP_W'(MAX_SIZE_LOG2)) ? EXP_W'(MAX_SIZE_LOG2) : wl_raw;
        hl = (hl_raw > EXP_W'(MAX_SIZE_LOG2)) ? EXP_W'(MAX_SIZE_LOG2) : hl_raw;
        m = (wl < hl) ? wl : hl;
        shared = {m, 1'b0};
        x_top = {1'b0, shared} + {2'b00, wl - m};
        y_top = {1'b0, shared} + {2'b00, hl - m};
        for (int b = 0; b < CODE_W; b++) begin
            if (b < int'(shared)) begin
                res.x_mask[b] = (b % 2) == 1;
                res.y_mask[b] = (b % 2) == 0;
            end else begin
                res.x_mask[b] = b < int'(x_top);
                res.y_mask[b] = b < int'(y_top);
            end
        end
        for (int b = 0; b < COUNT_W; b++) begin
            res.col_last[b] = b < int'(wl);
            res.row_last[b] = b < int'(hl);
        end
        return res;
    endfunction

endpackage

// ----- design/rta_shape_regs.sv -----
// Size exponent registers and the registered interleave masks built from them.
module rta_shape_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rta_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rta_pkg::EXP_W-1:0]     i_cfg_data,
    output rta_pkg::t_shape               o_shape,
    output logic                          o_restart
);

    logic [rta_pkg::EXP_W-1:0] r_width_log2;
    logic [rta_pkg::EXP_W-1:0] r_height_log2;
    logic [rta_pkg::EXP_W-1:0] n_width_log2;
    logic [rta_pkg::EXP_W-1:0] n_height_log2;
    rta_pkg::t_shape           r_shape;
    logic                      hit;

    // Decode a register write; unknown indexes leave everything unchanged.
    always_comb begin
        n_width_log2  = r_width_log2;
        n_height_log2 = r_height_log2;
        hit           = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                rta_pkg::CFG_WIDTH_LOG2: begin
                    n_width_log2 = i_cfg_data;
                    hit          = 1'b1;
                end
                rta_pkg::CFG_HEIGHT_LOG2: begin
                    n_height_log2 = i_cfg_data;
                    hit           = 1'b1;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // Masks are rebuilt from the new exponents so they are ready next cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_log2  <= '0;
            r_height_log2 <= '0;
            r_shape       <= rta_pkg::build_shape('0, '0);
        end else begin
            r_width_log2  <= n_width_log2;
            r_height_log2 <= n_height_log2;
            r_shape       <= rta_pkg::build_shape(n_width_log2, n_height_log2);
        end
    end

    assign o_shape   = r_shape;
    assign o_restart = hit;

endmodule

// ----- design/rta_code_counter.sv -----
// Running x and y Morton codes and the raster position counters.
module rta_code_counter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_restart,
    input  logic                       i_advance,
    input  rta_pkg::t_shape            i_shape,
    output logic [rta_pkg::ADDR_W-1:0] o_address,
    output logic                       o_is_last
);

    logic [rta_pkg::CODE_W-1:0]  r_x_code;
    logic [rta_pkg::CODE_W-1:0]  r_y_code;
    logic [rta_pkg::COUNT_W-1:0] r_col;
    logic [rta_pkg::COUNT_W-1:0] r_row;
    logic [rta_pkg::CODE_W-1:0]  n_x_code;
    logic [rta_pkg::CODE_W-1:0]  n_y_code;
    logic [rta_pkg::COUNT_W-1:0] n_col;
    logic [rta_pkg::COUNT_W-1:0] n_row;
    logic                        last_col;
    logic                        last_row;

    assign last_col = r_col >= i_shape.col_last;
    assign last_row = r_row >= i_shape.row_last;

    // Step to the next pixel; a masked add moves each code by one position.
    always_comb begin
        n_x_code = r_x_code;
        n_y_code = r_y_code;
        n_col    = r_col;
        n_row    = r_row;
        if (i_restart) begin
            n_x_code = '0;
            n_y_code = '0;
            n_col    = '0;
            n_row    = '0;
        end else if (i_advance) begin
            if (last_col) begin
                n_col    = '0;
                n_x_code = '0;
                if (last_row) begin
                    n_row    = '0;
                    n_y_code = '0;
                end else begin
                    n_row    = r_row + 1'b1;
                    n_y_code = (r_y_code - i_shape.y_mask) & i_shape.y_mask;
                end
            end else begin
                n_col    = r_col + 1'b1;
                n_x_code = (r_x_code - i_shape.x_mask) & i_shape.x_mask;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_code <= '0;
            r_y_code <= '0;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_x_code <= n_x_code;
            r_y_code <= n_y_code;
            r_col    <= n_col;
            r_row    <= n_row;
        end
    end

    assign o_address = r_x_code | r_y_code;
    assign o_is_last = last_col & last_row;

endmodule

// ----- design/rta_out_skid.sv -----
// Output register with a skid stage so the input side keeps flowing.
module rta_out_skid (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [rta_pkg::ADDR_W-1:0]  i_address,
    input  logic [rta_pkg::PIXEL_W-1:0] i_pixel,
    input  logic                        i_is_last,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rta_pkg::ADDR_W-1:0]  o_address,
    output logic [rta_pkg::PIXEL_W-1:0] o_pixel,
    output logic                        o_is_last
);

    logic                        r_out_valid;
    logic [rta_pkg::ADDR_W-1:0]  r_out_address;
    logic [rta_pkg::PIXEL_W-1:0] r_out_pixel;
    logic                        r_out_last;
    logic                        r_sk_valid;
    logic [rta_pkg::ADDR_W-1:0]  r_sk_address;
    logic [rta_pkg::PIXEL_W-1:0] r_sk_pixel;
    logic                        r_sk_last;
    logic                        n_out_valid;
    logic [rta_pkg::ADDR_W-1:0]  n_out_address;
    logic [rta_pkg::PIXEL_W-1:0] n_out_pixel;
    logic                        n_out_last;
    logic                        n_sk_valid;
    logic [rta_pkg::ADDR_W-1:0]  n_sk_address;
    logic [rta_pkg::PIXEL_W-1:0] n_sk_pixel;
    logic                        n_sk_last;
    logic                        in_acc;
    logic                        out_acc;

    assign in_acc  = i_in_valid & ~r_sk_valid;
    assign out_acc = r_out_valid & ~i_out_stall;

    // Move the skid item forward first; otherwise a new item goes to the
    // output register when it is free, and to the skid stage when it is not.
    always_comb begin
        n_out_valid   = r_out_valid & ~out_acc;
        n_out_address = r_out_address;
        n_out_pixel   = r_out_pixel;
        n_out_last    = r_out_last;
        n_sk_valid    = r_sk_valid;
        n_sk_address  = r_sk_address;
        n_sk_pixel    = r_sk_pixel;
        n_sk_last     = r_sk_last;
        if (r_sk_valid && (out_acc || !r_out_valid)) begin
            n_out_valid   = 1'b1;
            n_out_address = r_sk_address;
            n_out_pixel   = r_sk_pixel;
            n_out_last    = r_sk_last;
            n_sk_valid    = 1'b0;
        end else if (in_acc) begin
            if (!r_out_valid || out_acc) begin
                n_out_valid   = 1'b1;
                n_out_address = i_address;
                n_out_pixel   = i_pixel;
                n_out_last    = i_is_last;
            end else begin
                n_sk_valid   = 1'b1;
                n_sk_address = i_address;
                n_sk_pixel   = i_pixel;
                n_sk_last    = i_is_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_sk_valid  <= n_sk_valid;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        r_out_address <= n_out_address;
        r_out_pixel   <= n_out_pixel;
        r_out_last    <= n_out_last;
        r_sk_address  <= n_sk_address;
        r_sk_pixel    <= n_sk_pixel;
        r_sk_last     <= n_sk_last;
    end

    assign o_in_stall  = r_sk_valid;
    assign o_out_valid = r_out_valid;
    assign o_address   = r_out_address;
    assign o_pixel     = r_out_pixel;
    assign o_is_last   = r_out_last;

endmodule

// ----- design/raster_to_twiddled_address_unit.sv -----
// Top level of the raster to twiddled (Morton order) address unit.
//
// Usage: write width_log2 (index 0) and height_log2 (index 1) on the config
// port while the unit is idle; every write to either register restarts the
// texture at its first pixel. Exponents above 10 act as 10. Then send the
// pixels in raster order on the input channel (i_in_valid / o_in_stall).
// Each item comes back on the output channel (o_out_valid / i_out_stall)
// with its twiddled element index, the pixel itself and a last flag on the
// final pixel of the texture; the next pixel begins a new texture.
// An accepted item goes to the output register, or to the skid stage when
// that is held. One item is taken every cycle while o_in_stall is low; the
// masked add on the running codes sets that rate. Masks are registered from
// the exponents, so an item may follow a config write in the next cycle.
// When the receiver stalls, one further item is caught in a skid stage and
// o_in_stall then rises until it drains. After reset both exponents are
// zero (a 1x1 texture) and both channels are empty.
module raster_to_twiddled_address_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rta_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rta_pkg::EXP_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rta_pkg::PIXEL_W-1:0]   i_pixel_value,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rta_pkg::ADDR_W-1:0]    o_twiddled_address,
    output logic [rta_pkg::PIXEL_W-1:0]   o_pixel_out,
    output logic                          o_is_last
);

    rta_pkg::t_shape            shape;
    logic                       restart;
    logic                       in_acc;
    logic [rta_pkg::ADDR_W-1:0] cur_address;
    logic                       cur_last;

    assign in_acc = i_in_valid & ~o_in_stall;

    // Configuration registers and interleave masks.
    rta_shape_regs u_shape (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_shape     (shape),
        .o_restart   (restart)
    );

    // Address of the current pixel; steps once per accepted item.
    rta_code_counter u_codes (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_advance (in_acc),
        .i_shape   (shape),
        .o_address (cur_address),
        .o_is_last (cur_last)
    );

    // Result register and skid stage.
    rta_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_address   (cur_address),
        .i_pixel     (i_pixel_value),
        .i_is_last   (cur_last),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_address   (o_twiddled_address),
        .o_pixel     (o_pixel_out),
        .o_is_last   (o_is_last)
    );

endmodule
